### hw/rtl/kcv_pkg.sv
`default_nettype none

package kcv_pkg;

    localparam int KCV_WORD_WIDTH = 48;
    localparam int KCV_FRAC_BITS  = 16;

    // external number format: Q32.16 in 48 bits
    localparam int IO_WIDTH = 48;
    localparam int IO_FRAC  = 16;
    localparam int CFG_W    = 32;
    localparam int DT_W     = 32;
    localparam int IDX_W    = 5;

    localparam int IN_IDX_LSB = 0;
    localparam int IN_VAL_LSB = 5;
    localparam int IN_ME_LSB  = 53;
    localparam int IN_MN_LSB  = 101;
    localparam int IN_DT_LSB  = 149;
    localparam int S_TDATA_W  = 184;
    localparam int OUT_WORDS  = 8;
    localparam int M_TDATA_W  = OUT_WORDS * IO_WIDTH;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FILTER = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 32'h0001_0000;

    localparam int ADDR_W      = 7;
    localparam int MEM_DEPTH   = 128;
    localparam int STATE_DEPTH = 20;
    localparam int PC_W        = 9;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PC_W-1:0]   pc_t;

    typedef enum logic [2:0] {
        OP_MAC,
        OP_ADD,
        OP_SUB,
        OP_DIV,
        OP_CHK,
        OP_END
    } op_t;

    typedef struct packed {
        op_t   op;
        addr_t a;
        addr_t b;
        addr_t d;
        logic  clr;
    } instr_t;

    typedef struct packed {
        logic start;
        op_t  op;
        logic clr;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic busy;
    } alu_rsp_t;

    // scratch map: x, P, K, innovation, S, det, Sinv, temps, I-KH, T, new x
    localparam addr_t A_X    = 7'd0;
    localparam addr_t A_P    = 7'd4;
    localparam addr_t A_K    = 7'd20;
    localparam addr_t A_Y0   = 7'd28;
    localparam addr_t A_Y1   = 7'd29;
    localparam addr_t A_S00  = 7'd30;
    localparam addr_t A_S11  = 7'd31;
    localparam addr_t A_DET  = 7'd32;
    localparam addr_t A_I00  = 7'd33;
    localparam addr_t A_I01  = 7'd34;
    localparam addr_t A_I10  = 7'd35;
    localparam addr_t A_I11  = 7'd36;
    localparam addr_t A_T0   = 7'd37;
    localparam addr_t A_T1   = 7'd38;
    localparam addr_t A_T2   = 7'd39;
    localparam addr_t A_IKH  = 7'd40;
    localparam addr_t A_TM   = 7'd64;
    localparam addr_t A_NX   = 7'd80;
    // operands that come from constants or registers, not from the scratch memory
    localparam addr_t A_ZERO = 7'd96;
    localparam addr_t A_ONE  = 7'd97;
    localparam addr_t A_R    = 7'd98;
    localparam addr_t A_DT   = 7'd99;
    localparam addr_t A_ME   = 7'd100;
    localparam addr_t A_MN   = 7'd101;

    localparam pc_t PC_K   = 9'd14;
    localparam pc_t PC_XU  = 9'd30;
    localparam pc_t PC_IKH = 9'd46;
    localparam pc_t PC_T   = 9'd62;
    localparam pc_t PC_FX  = 9'd126;
    localparam pc_t PC_CP  = 9'd142;
    localparam pc_t PC_I2  = 9'd146;
    localparam pc_t PC_PN  = 9'd210;
    localparam pc_t PC_END = 9'd274;

    function automatic instr_t mk(input op_t op, input addr_t a, input addr_t b,
                                  input addr_t d, input logic clr);
        instr_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.d   = d;
        u.clr = clr;
        return u;
    endfunction

    // constant-velocity transition matrix
    function automatic addr_t fm_addr(input logic [1:0] r, input logic [1:0] c);
        if (r == c)
            return A_ONE;
        if ((r == 2'd0 && c == 2'd2) || (r == 2'd1 && c == 2'd3))
            return A_DT;
        return A_ZERO;
    endfunction

    // microprogram of one filter step
    function automatic instr_t ucode(input pc_t pc);
        instr_t     u;
        pc_t        o;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k;
        addr_t      id;
        u  = mk(OP_END, A_ZERO, A_ZERO, A_T2, 1'b1);
        o  = '0;
        id = A_ZERO;
        if (pc < PC_K) begin
            case (pc[3:0])
                4'd0:    u = mk(OP_SUB, A_ME, A_X, A_Y0, 1'b1);
                4'd1:    u = mk(OP_SUB, A_MN, A_X + 7'd1, A_Y1, 1'b1);
                4'd2:    u = mk(OP_ADD, A_P, A_R, A_S00, 1'b1);
                4'd3:    u = mk(OP_ADD, A_P + 7'd5, A_R, A_S11, 1'b1);
                4'd4:    u = mk(OP_MAC, A_S00, A_S11, A_T1, 1'b1);
                4'd5:    u = mk(OP_MAC, A_P + 7'd1, A_P + 7'd4, A_T2, 1'b1);
                4'd6:    u = mk(OP_SUB, A_T1, A_T2, A_DET, 1'b1);
                4'd7:    u = mk(OP_CHK, A_DET, A_DET, A_T2, 1'b1);
                4'd8:    u = mk(OP_DIV, A_S11, A_DET, A_I00, 1'b1);
                4'd9:    u = mk(OP_SUB, A_ZERO, A_P + 7'd1, A_T0, 1'b1);
                4'd10:   u = mk(OP_DIV, A_T0, A_DET, A_I01, 1'b1);
                4'd11:   u = mk(OP_SUB, A_ZERO, A_P + 7'd4, A_T0, 1'b1);
                4'd12:   u = mk(OP_DIV, A_T0, A_DET, A_I10, 1'b1);
                default: u = mk(OP_DIV, A_S00, A_DET, A_I11, 1'b1);
            endcase
        end else if (pc < PC_XU) begin
            // K = P[.][0..1] * Sinv; o = {i, c, k}
            o = pc - PC_K;
            i = o[3:2];
            u = mk(OP_MAC, A_P + addr_t'({i, 1'b0, o[0]}), A_I00 + addr_t'({o[0], o[1]}),
                   A_K + addr_t'({i, o[1]}), !o[0]);
        end else if (pc < PC_IKH) begin
            o = pc - PC_XU;
            i = o[3:2];
            case (o[1:0])
                2'd0:    u = mk(OP_MAC, A_K + addr_t'({i, 1'b0}), A_Y0, A_T1, 1'b1);
                2'd1:    u = mk(OP_MAC, A_K + addr_t'({i, 1'b1}), A_Y1, A_T1, 1'b0);
                2'd2:    u = mk(OP_ADD, A_X + addr_t'(i), A_T1, A_X + addr_t'(i), 1'b1);
                default: u = mk(OP_ADD, A_T1, A_ZERO, A_T1, 1'b1);
            endcase
        end else if (pc < PC_T) begin
            o  = pc - PC_IKH;
            i  = o[3:2];
            j  = o[1:0];
            id = (i == j) ? A_ONE : A_ZERO;
            if (!j[1])
                u = mk(OP_SUB, id, A_K + addr_t'({i, j[0]}), A_IKH + addr_t'({i, j}), 1'b1);
            else
                u = mk(OP_ADD, id, A_ZERO, A_IKH + addr_t'({i, j}), 1'b1);
        end else if (pc < PC_FX) begin
            o = pc - PC_T;
            i = o[5:4];
            j = o[3:2];
            k = o[1:0];
            u = mk(OP_MAC, A_IKH + addr_t'({i, k}), A_P + addr_t'({k, j}),
                   A_TM + addr_t'({i, j}), k == 2'd0);
        end else if (pc < PC_CP) begin
            o = pc - PC_FX;
            i = o[3:2];
            j = o[1:0];
            u = mk(OP_MAC, fm_addr(i, j), A_X + addr_t'(j), A_NX + addr_t'(i), j == 2'd0);
        end else if (pc < PC_I2) begin
            o = pc - PC_CP;
            i = o[1:0];
            u = mk(OP_ADD, A_NX + addr_t'(i), A_ZERO, A_X + addr_t'(i), 1'b1);
        end else if (pc < PC_PN) begin
            o = pc - PC_I2;
            i = o[5:4];
            j = o[3:2];
            k = o[1:0];
            u = mk(OP_MAC, A_TM + addr_t'({i, k}), fm_addr(j, k),
                   A_IKH + addr_t'({i, j}), k == 2'd0);
        end else if (pc < PC_END) begin
            o = pc - PC_PN;
            i = o[5:4];
            j = o[3:2];
            k = o[1:0];
            u = mk(OP_MAC, fm_addr(i, k), A_IKH + addr_t'({k, j}),
                   A_P + addr_t'({i, j}), k == 2'd0);
        end
        return u;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/kcv_regfile.sv
`default_nettype none

module kcv_regfile #(
    parameter int WIDTH = kcv_pkg::KCV_WORD_WIDTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                we,
    input  wire kcv_pkg::addr_t      waddr,
    input  wire logic [WIDTH-1:0]    wdata,
    input  wire kcv_pkg::addr_t      ra_addr,
    input  wire kcv_pkg::addr_t      rb_addr,
    output logic [WIDTH-1:0]         ra_data,
    output logic [WIDTH-1:0]         rb_data
);
    import kcv_pkg::*;

    localparam int SW = $clog2(STATE_DEPTH);

    logic [WIDTH-1:0]       mem [MEM_DEPTH];
    logic [STATE_DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0]       ra_q_reg;
    logic [WIDTH-1:0]       rb_q_reg;
    logic                   ra_ok_reg;
    logic                   rb_ok_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        ra_q_reg  <= mem[ra_addr];
        rb_q_reg  <= mem[rb_addr];
        ra_ok_reg <= (ra_addr >= addr_t'(STATE_DEPTH)) || valid_reg[ra_addr[SW-1:0]];
        rb_ok_reg <= (rb_addr >= addr_t'(STATE_DEPTH)) || valid_reg[rb_addr[SW-1:0]];
    end

    // state entries read as zero until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (we && waddr < addr_t'(STATE_DEPTH))
            valid_reg[waddr[SW-1:0]] <= 1'b1;
    end

    assign ra_data = ra_ok_reg ? ra_q_reg : '0;
    assign rb_data = rb_ok_reg ? rb_q_reg : '0;

endmodule

`default_nettype wire

### hw/rtl/kcv_alu.sv
`default_nettype none

module kcv_alu #(
    parameter int WORD_WIDTH = kcv_pkg::KCV_WORD_WIDTH,
    parameter int FRAC_BITS  = kcv_pkg::KCV_FRAC_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire kcv_pkg::alu_req_t      req,
    input  wire logic [WORD_WIDTH-1:0]  a,
    input  wire logic [WORD_WIDTH-1:0]  b,
    output kcv_pkg::alu_rsp_t           rsp,
    output logic [WORD_WIDTH-1:0]       result
);
    import kcv_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int NW = WORD_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [5:0] {
        AS_IDLE = 6'b000001,
        AS_MUL  = 6'b000010,
        AS_RND  = 6'b000100,
        AS_ACC  = 6'b001000,
        AS_DIV  = 6'b010000,
        AS_DSAT = 6'b100000
    } alu_state_t;

    alu_state_t       state_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic             neg_reg;
    logic             clr_reg;
    logic [63:0]      ma_reg;
    logic [63:0]      mb_reg;
    logic [63:0]      pp_reg;
    logic [1:0]       pp_sh_reg;
    logic [127:0]     prod_reg;
    logic [W-1:0]     mres_reg;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     result_reg;
    logic [NW-1:0]    num_reg;
    logic [NW-1:0]    quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dv_reg;

    logic [31:0]      mul_x;
    logic [31:0]      mul_y;
    logic [63:0]      mul_p;
    logic [127:0]     rnd_q;
    logic [W:0]       rsh;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic sub);
        logic [W:0] s;
        s = sub ? ({x[W-1], x} - {y[W-1], y}) : ({x[W-1], x} + {y[W-1], y});
        if (s[W] != s[W-1])
            return s[W] ? MINV : MAXV;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_mag(input logic [127:0] m, input logic neg);
        logic [127:0] lim;
        lim = 128'd1 << (W - 1);
        if (neg)
        begin
            if (m >= lim)
                return MINV;
            return ~m[W-1:0] + 1'b1;
        end
        if (m >= lim)
            return MAXV;
        return m[W-1:0];
    endfunction

    assign mul_x = ma_reg[{cnt_reg[1], 5'b00000} +: 32];
    assign mul_y = mb_reg[{cnt_reg[0], 5'b00000} +: 32];
    assign mul_p = mul_x * mul_y;
    assign rnd_q = (prod_reg + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign rsh   = {rem_reg, num_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                AS_IDLE:
                begin
                    cnt_reg <= '0;
                    if (req.start)
                    begin
                        case (req.op)
                            OP_MAC:  state_reg <= AS_MUL;
                            OP_DIV:  state_reg <= AS_DIV;
                            OP_ADD, OP_SUB: done_reg <= 1'b1;
                            default: state_reg <= AS_IDLE;
                        endcase
                    end
                end
                AS_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(4))
                        state_reg <= AS_RND;
                end
                AS_RND:
                    state_reg <= AS_ACC;
                AS_ACC:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= AS_IDLE;
                end
                AS_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(NW - 1))
                        state_reg <= AS_DSAT;
                end
                AS_DSAT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= AS_IDLE;
                end
                default:
                    state_reg <= AS_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            AS_IDLE:
            begin
                if (req.start)
                begin
                    neg_reg  <= a[W-1] ^ b[W-1];
                    clr_reg  <= req.clr;
                    ma_reg   <= 64'(mag(a));
                    mb_reg   <= 64'(mag(b));
                    prod_reg <= '0;
                    num_reg  <= {mag(a), {FRAC_BITS{1'b0}}};
                    dv_reg   <= mag(b);
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    if (req.op == OP_ADD)
                        result_reg <= sat_add(a, b, 1'b0);
                    else if (req.op == OP_SUB)
                        result_reg <= sat_add(a, b, 1'b1);
                end
            end
            AS_MUL:
            begin
                // one 32x32 partial product per cycle, summed in the cycle after
                if (cnt_reg < CW'(4))
                begin
                    pp_reg    <= mul_p;
                    pp_sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                end
                if (cnt_reg != '0)
                    prod_reg <= prod_reg + ({64'd0, pp_reg} << {pp_sh_reg, 5'b00000});
            end
            AS_RND:
                mres_reg <= sat_mag(rnd_q, neg_reg);
            AS_ACC:
            begin
                acc_reg    <= sat_add(clr_reg ? '0 : acc_reg, mres_reg, 1'b0);
                result_reg <= sat_add(clr_reg ? '0 : acc_reg, mres_reg, 1'b0);
            end
            AS_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rsh >= {1'b0, dv_reg})
                begin
                    rem_reg <= W'(rsh - {1'b0, dv_reg});
                    quo_reg <= {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rsh[W-1:0];
                    quo_reg <= {quo_reg[NW-2:0], 1'b0};
                end
                num_reg <= {num_reg[NW-2:0], 1'b0};
            end
            AS_DSAT:
                result_reg <= sat_mag({{(128-NW){1'b0}}, quo_reg}, neg_reg);
            default:
                result_reg <= result_reg;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.busy = (state_reg != AS_IDLE);
    assign result   = result_reg;

endmodule

`default_nettype wire

### hw/rtl/constant_velocity_kalman_2d_top.sv
`default_nettype none

// Channel  | Signals                                  | Item
// ---------+------------------------------------------+-------------------------------
// s_axis   | tvalid tready tdata[183:0] tuser[0]      | load or filter command
// m_axis   | tvalid tready tdata[383:0] tuser[0]      | estimate, P diagonal, singular
// cfg      | valid ready data[31:0]                   | measurement variance R
//
// A load item is written when it is accepted. A filter step runs 234 multiply-accumulates
// on the one 32x32 multiplier, plus four divides in the bit-serial divider. A singular
// innovation ends the step at the determinant check. s_axis_tready is high only while the
// sequencer is idle; a new result waits until the previous one is taken. Reset makes x and
// P read as zero and sets R to 1.0; no clearing pass is needed.
module constant_velocity_kalman_2d_top #(
    parameter int WORD_WIDTH = kcv_pkg::KCV_WORD_WIDTH,
    parameter int FRAC_BITS  = kcv_pkg::KCV_FRAC_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // load_index, load_value, meas_east, meas_north, delta_t, zero pad
    input  wire logic [kcv_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // opcode
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // est_east, est_north, est_vel_east, est_vel_north,
    // var_east, var_north, var_vel_east, var_vel_north
    output logic [kcv_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // singular
    output logic                                 m_axis_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kcv_pkg::CFG_W-1:0]       cfg_data
);
    import kcv_pkg::*;

    localparam int W      = WORD_WIDTH;
    localparam int WIDE   = 88;
    localparam int UP_IN  = (FRAC_BITS >= IO_FRAC) ? FRAC_BITS - IO_FRAC : 0;
    localparam int DN_IN  = (FRAC_BITS < IO_FRAC) ? IO_FRAC - FRAC_BITS : 1;
    localparam int UP_OUT = (FRAC_BITS <= IO_FRAC) ? IO_FRAC - FRAC_BITS : 0;
    localparam int DN_OUT = (FRAC_BITS > IO_FRAC) ? FRAC_BITS - IO_FRAC : 1;
    localparam logic [W-1:0] MAXV_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ONE_W  =
        (FRAC_BITS >= W - 1) ? MAXV_W : (W'(1) << FRAC_BITS);
    localparam logic signed [WIDE-1:0] WMAX =
        $signed({{(WIDE-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [WIDE-1:0] WMIN = ~WMAX;
    localparam logic signed [WIDE-1:0] OMAX =
        $signed({{(WIDE-IO_WIDTH+1){1'b0}}, {(IO_WIDTH-1){1'b1}}});
    localparam logic signed [WIDE-1:0] OMIN = ~OMAX;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_FETCH   = 6'b000010,
        ST_OPER    = 6'b000100,
        ST_WAIT    = 6'b001000,
        ST_OUT_RD  = 6'b010000,
        ST_OUT_CAP = 6'b100000
    } seq_state_t;

    function automatic logic [W-1:0] conv_in(input logic [IO_WIDTH-1:0] v);
        logic signed [WIDE-1:0] t;
        t = $signed({{(WIDE-IO_WIDTH){v[IO_WIDTH-1]}}, v});
        if (FRAC_BITS >= IO_FRAC)
            t = t <<< UP_IN;
        else
            t = (t >>> DN_IN) + $signed({{(WIDE-1){1'b0}}, v[DN_IN-1]});
        if (t > WMAX)
            t = WMAX;
        else if (t < WMIN)
            t = WMIN;
        return t[W-1:0];
    endfunction

    function automatic logic [IO_WIDTH-1:0] conv_out(input logic [W-1:0] v);
        logic signed [WIDE-1:0] t;
        t = $signed({{(WIDE-W){v[W-1]}}, v});
        if (FRAC_BITS <= IO_FRAC)
            t = t <<< UP_OUT;
        else
            t = (t >>> DN_OUT) + $signed({{(WIDE-1){1'b0}}, v[DN_OUT-1]});
        if (t > OMAX)
            t = OMAX;
        else if (t < OMIN)
            t = OMIN;
        return t[IO_WIDTH-1:0];
    endfunction

    seq_state_t           state_reg;
    pc_t                  pc_reg;
    logic [CFG_W-1:0]     cfg_reg;
    logic [3:0]           out_cnt_reg;
    logic                 sing_reg;
    logic                 m_valid_reg;
    logic                 m_sing_reg;
    logic [W-1:0]         me_reg;
    logic [W-1:0]         mn_reg;
    logic [W-1:0]         dt_reg;
    logic [W-1:0]         r_reg;
    logic [IO_WIDTH-1:0]  out_word_reg [OUT_WORDS];

    instr_t               ins;
    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;
    logic [W-1:0]         alu_result;
    logic [W-1:0]         ra_data;
    logic [W-1:0]         rb_data;
    logic [W-1:0]         opa;
    logic [W-1:0]         opb;
    addr_t                ra_addr;
    addr_t                out_addr;
    logic                 we;
    addr_t                waddr;
    logic [W-1:0]         wdata;
    logic                 in_accept;
    logic [IDX_W-1:0]     load_idx;

    function automatic logic [W-1:0] pick(input addr_t ad, input logic [W-1:0] mem_v,
                                          input logic [W-1:0] r_v, input logic [W-1:0] dt_v,
                                          input logic [W-1:0] me_v, input logic [W-1:0] mn_v);
        case (ad)
            A_ZERO:  return '0;
            A_ONE:   return ONE_W;
            A_R:     return r_v;
            A_DT:    return dt_v;
            A_ME:    return me_v;
            A_MN:    return mn_v;
            default: return mem_v;
        endcase
    endfunction

    assign ins       = ucode(pc_reg);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign load_idx  = s_axis_tdata[IN_IDX_LSB +: IDX_W];

    always_comb
    begin
        unique case (out_cnt_reg[2:0])
            3'd0:    out_addr = A_X;
            3'd1:    out_addr = A_X + 7'd1;
            3'd2:    out_addr = A_X + 7'd2;
            3'd3:    out_addr = A_X + 7'd3;
            3'd4:    out_addr = A_P;
            3'd5:    out_addr = A_P + 7'd5;
            3'd6:    out_addr = A_P + 7'd10;
            default: out_addr = A_P + 7'd15;
        endcase
    end

    assign ra_addr = (state_reg == ST_OUT_RD) ? out_addr : ins.a;
    assign opa     = pick(ins.a, ra_data, r_reg, dt_reg, me_reg, mn_reg);
    assign opb     = pick(ins.b, rb_data, r_reg, dt_reg, me_reg, mn_reg);

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            we    = in_accept && (s_axis_tuser == CMD_LOAD) &&
                    (load_idx < IDX_W'(STATE_DEPTH));
            waddr = addr_t'(load_idx);
            wdata = conv_in(s_axis_tdata[IN_VAL_LSB +: IO_WIDTH]);
        end
        else
        begin
            we    = (state_reg == ST_WAIT) && alu_rsp.done;
            waddr = ins.d;
            wdata = alu_result;
        end
    end

    assign alu_req.start = (state_reg == ST_OPER) && (ins.op != OP_CHK);
    assign alu_req.op    = ins.op;
    assign alu_req.clr   = ins.clr;

    kcv_regfile #(
        .WIDTH (WORD_WIDTH)
    ) u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .ra_addr (ra_addr),
        .rb_addr (ins.b),
        .ra_data (ra_data),
        .rb_data (rb_data)
    );

    kcv_alu #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (opa),
        .b      (opb),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            cfg_reg     <= CFG_RESET;
            out_cnt_reg <= '0;
            sing_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            m_sing_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                cfg_reg <= cfg_data;
            if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && s_axis_tuser == CMD_FILTER)
                    begin
                        pc_reg    <= '0;
                        sing_reg  <= 1'b0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    out_cnt_reg <= '0;
                    if (ins.op == OP_END)
                        state_reg <= ST_OUT_RD;
                    else
                        state_reg <= ST_OPER;
                end
                ST_OPER:
                begin
                    if (ins.op == OP_CHK)
                    begin
                        // zero determinant: report the state as it stands
                        if (opa == '0)
                        begin
                            sing_reg  <= 1'b1;
                            state_reg <= ST_OUT_RD;
                        end
                        else
                        begin
                            pc_reg    <= pc_reg + 1'b1;
                            state_reg <= ST_FETCH;
                        end
                    end
                    else
                        state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (alu_rsp.done)
                    begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_OUT_RD:
                begin
                    // hold until the previous result item is taken
                    if (!m_valid_reg)
                        state_reg <= ST_OUT_CAP;
                end
                ST_OUT_CAP:
                begin
                    if (out_cnt_reg == 4'd7)
                    begin
                        m_valid_reg <= 1'b1;
                        m_sing_reg  <= sing_reg;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        out_cnt_reg <= out_cnt_reg + 1'b1;
                        state_reg   <= ST_OUT_RD;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && s_axis_tuser == CMD_FILTER)
        begin
            me_reg <= conv_in(s_axis_tdata[IN_ME_LSB +: IO_WIDTH]);
            mn_reg <= conv_in(s_axis_tdata[IN_MN_LSB +: IO_WIDTH]);
            dt_reg <= conv_in({{(IO_WIDTH-DT_W){1'b0}}, s_axis_tdata[IN_DT_LSB +: DT_W]});
            r_reg  <= conv_in({{(IO_WIDTH-CFG_W){1'b0}}, cfg_reg});
        end
        if (state_reg == ST_OUT_CAP)
            out_word_reg[out_cnt_reg[2:0]] <= conv_out(ra_data);
    end

    always_comb
    begin
        for (int n = 0; n < OUT_WORDS; n++)
            m_axis_tdata[n*IO_WIDTH +: IO_WIDTH] = out_word_reg[n];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_sing_reg;
    assign cfg_ready     = 1'b1;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == ST_WAIT))
        else $error("arithmetic unit finished outside the wait state");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> !alu_rsp.busy)
        else $error("arithmetic unit started while busy");

    a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> (pc_reg <= PC_END))
        else $error("microprogram counter ran past the end");

    a_readout_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT_CAP) |-> !m_axis_tvalid)
        else $error("result readout overlaps a pending result item");

endmodule

`default_nettype wire
